/* rtl/delimited_frame_parser_macros.svh */
// Assertion macros used by rtl/delimited_frame_parser.sv.
`ifndef DELIMITED_FRAME_PARSER_MACROS_SVH
`define DELIMITED_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dfp_pkg.sv */
`default_nettype none

package dfp_pkg;

    localparam int unsigned LEN_W = 6;
    localparam int unsigned TDATA_W = 24;

    localparam logic [7:0] BYTE_START = 8'h24;
    localparam logic [7:0] BYTE_END = 8'h23;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_TRAIL   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BUSY     = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_FRAME    = 2'd3
    } status_t;

    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_EMIT   = 1'b1
    } state_t;

endpackage

`default_nettype wire

/* rtl/delimited_frame_parser.sv */
`default_nettype none

// Start/end delimited frame parser. Every transaction on the slave side is a
// received byte (s_tuser low) or a release of the busy flag (s_tuser high).
// A '$' opens a frame, a '#' closes it; the payload is kept in a payload
// memory with one write and one read port and, at the close, read back and
// sent as one transaction per byte with m_tlast on the final one, cut to
// OUT_MAX bytes. Every other input gives exactly one status transaction. A
// closing '#' with n stored bytes (n cut to OUT_MAX) is read out one byte per
// cycle while the master side does not stall, from the one registered read
// port of the payload memory; the slave side is held off during that
// readout. Until a release arrives after a frame, bytes are dropped.
`include "delimited_frame_parser_macros.svh"

module delimited_frame_parser #(
    parameter int unsigned WORK_DEPTH = 128,
    parameter int unsigned OUT_MAX = 63
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // data_byte [7:0]
    input  wire  [7:0]                   s_tdata,
    // action [0]
    input  wire                          s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // payload_byte [7:0], frame_length [13:8], parser_mode [15:14],
    // busy_flag [16], zero fill [23:17]
    output logic [dfp_pkg::TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);

    import dfp_pkg::*;

    localparam int unsigned AW = (WORK_DEPTH > 1) ? $clog2(WORK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(WORK_DEPTH + 1);

    logic [7:0] mem [WORK_DEPTH];
    logic [7:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;

    state_t state_reg, state_next;
    mode_t mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic pending_reg, pending_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] n_reg, n_next;

    logic m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic [LEN_W-1:0] m_len_reg, m_len_next;
    logic m_last_reg, m_last_next;
    mode_t m_mode_reg, m_mode_next;
    logic m_busy_reg, m_busy_next;

    logic out_free;
    logic s_accept;
    logic emit_last;
    logic [LEN_W-1:0] n_calc;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_ACCEPT) && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign emit_last = ({{(8-AW){1'b0}}, idx_reg} + 8'd1) == {{(8-LEN_W){1'b0}}, n_reg};
    assign n_calc = ({{(16-CW){1'b0}}, count_reg} > 16'(OUT_MAX)) ?
                    LEN_W'(OUT_MAX) : LEN_W'(count_reg);
    assign wr_addr = count_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        m_status_reg <= m_status_next;
        m_byte_reg   <= m_byte_next;
        m_len_reg    <= m_len_next;
        m_last_reg   <= m_last_next;
        m_mode_reg   <= m_mode_next;
        m_busy_reg   <= m_busy_next;
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        count_next    = count_reg;
        pending_next  = pending_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_byte_next   = m_byte_reg;
        m_len_next    = m_len_reg;
        m_last_next   = m_last_reg;
        m_mode_next   = m_mode_reg;
        m_busy_next   = m_busy_reg;
        unique case (state_reg)
            ST_ACCEPT: begin
                rd_addr = '0;
                if (s_accept) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_OK;
                    m_byte_next   = '0;
                    m_len_next    = '0;
                    m_last_next   = 1'b1;
                    if (s_tuser) begin
                        pending_next = 1'b0;
                    end else if (pending_reg) begin
                        m_status_next = STATUS_BUSY;
                    end else if (mode_reg == MODE_PAYLOAD) begin
                        if (s_tdata == BYTE_END) begin
                            pending_next  = 1'b1;
                            mode_next     = MODE_TRAIL;
                            m_status_next = STATUS_FRAME;
                            n_next        = n_calc;
                            idx_next      = '0;
                            if (n_calc != '0) begin
                                m_valid_next = 1'b0;
                                state_next   = ST_EMIT;
                            end
                        end else if (count_reg == CW'(WORK_DEPTH)) begin
                            count_next    = '0;
                            mode_next     = MODE_IDLE;
                            m_status_next = STATUS_OVERFLOW;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end else if (s_tdata == BYTE_START) begin
                        count_next = '0;
                        mode_next  = MODE_PAYLOAD;
                    end else if (mode_reg != MODE_TRAIL) begin
                        mode_next = MODE_IDLE;
                    end
                    m_mode_next = mode_next;
                    m_busy_next = pending_next;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_FRAME;
                    m_byte_next   = rd_data_reg;
                    m_len_next    = n_reg;
                    m_last_next   = emit_last;
                    m_mode_next   = mode_reg;
                    m_busy_next   = pending_reg;
                    if (emit_last) begin
                        state_next = ST_ACCEPT;
                        rd_addr    = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'd0, m_busy_reg, m_mode_reg, m_len_reg, m_byte_reg};

    `DFP_ASSERT_SAME(a_no_input_in_readout, aclk, aresetn, state_reg == ST_EMIT,
        !s_tready, "input taken during frame readout")
    `DFP_ASSERT_SAME(a_readout_state, aclk, aresetn, state_reg == ST_EMIT,
        (mode_reg == MODE_TRAIL) && pending_reg, "readout outside a pending frame")
    `DFP_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1,
        {{(16-CW){1'b0}}, count_reg} <= 16'(WORK_DEPTH), "payload count beyond memory depth")
    `DFP_ASSERT_SAME(a_mid_frame_in_readout, aclk, aresetn,
        m_valid_reg && (m_status_reg == STATUS_FRAME) && !m_last_reg,
        state_reg == ST_EMIT, "frame byte without last outside readout")
    `DFP_ASSERT_NEXT(a_frame_close, aclk, aresetn,
        s_accept && !s_tuser && !pending_reg && (mode_reg == MODE_PAYLOAD) && (s_tdata == BYTE_END),
        pending_reg && (mode_reg == MODE_TRAIL), "frame close did not set busy")

endmodule

`default_nettype wire
